// ===== hw/rtl/rbd_pkg.sv =====
// Shared constants and types of the run-length byte decoder.
package rbd_pkg;

	localparam int COUNT_BITS  = 6;
	localparam int LENGTH_BITS = 16;
	localparam int CFG_BITS    = 16;
	localparam int BYTE_BITS   = 8;

	// Header codes in bits 7..6 of a header byte.
	localparam logic [1:0] CODE_LITERAL = 2'b00;
	localparam logic [1:0] CODE_REPEAT  = 2'b01;
	localparam logic [1:0] CODE_ZEROS   = 2'b10;
	localparam logic [1:0] CODE_ONES    = 2'b11;

	localparam logic [BYTE_BITS-1:0] FILL_ZERO = 8'h00;
	localparam logic [BYTE_BITS-1:0] FILL_ONE  = 8'hFF;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_LITERAL = 3'b010,
		PH_VALUE   = 3'b100
	} phase_t;

	// One unit of back-end work: emit value count times.
	typedef struct packed {
		logic [BYTE_BITS-1:0]  value;
		logic [COUNT_BITS-1:0] count;
		logic                  end_run;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} push_t;

	typedef struct packed {
		logic empty;
		cmd_t head;
	} head_t;

endpackage

// ===== hw/rtl/rbd_if.sv =====
// Valid/ready channel interfaces for the compressed input and decoded output.
interface rbd_in_if;
	logic                           valid;
	logic                           ready;
	logic [rbd_pkg::BYTE_BITS-1:0] code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink (input valid, input code_byte, output ready);
endinterface

interface rbd_out_if;
	logic                           valid;
	logic                           ready;
	logic [rbd_pkg::BYTE_BITS-1:0] data_byte;
	logic                           run_last;
	logic                           block_done;
	logic                           overrun;

	modport source (output valid, output data_byte, output run_last, output block_done,
		output overrun, input ready);
	modport sink (input valid, input data_byte, input run_last, input block_done,
		input overrun, output ready);
endinterface

// ===== hw/rtl/rbd_front.sv =====
// Front end: accepts compressed bytes, tracks the header phase and issues emit commands.
module rbd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	rbd_in_if.sink            code,
	input  logic              q_full,
	output rbd_pkg::push_t    push
);

	rbd_pkg::phase_t                phase_q;
	logic [rbd_pkg::COUNT_BITS-1:0] run_left_q;
	rbd_pkg::phase_t                phase_d;
	logic [rbd_pkg::COUNT_BITS-1:0] run_left_d;
	logic [rbd_pkg::COUNT_BITS-1:0] lit_left;
	logic [rbd_pkg::COUNT_BITS-1:0] hdr_count;
	logic [1:0]                     hdr_code;
	logic                           accept;

	assign code.ready = !q_full;
	assign accept     = code.valid && code.ready;
	assign lit_left   = run_left_q - rbd_pkg::COUNT_BITS'(1);
	assign hdr_count  = code.code_byte[rbd_pkg::COUNT_BITS-1:0];
	assign hdr_code   = code.code_byte[7:6];

	always_comb begin
		phase_d              = phase_q;
		run_left_d           = run_left_q;
		push.push            = 1'b0;
		push.cmd.value       = code.code_byte;
		push.cmd.count       = rbd_pkg::COUNT_BITS'(1);
		push.cmd.end_run     = 1'b1;
		unique case (phase_q)
			rbd_pkg::PH_LITERAL: begin
				run_left_d       = lit_left;
				push.push        = accept;
				push.cmd.end_run = (lit_left == '0);
				if (lit_left == '0) begin
					phase_d = rbd_pkg::PH_HEADER;
				end
			end
			rbd_pkg::PH_VALUE: begin
				run_left_d     = '0;
				phase_d        = rbd_pkg::PH_HEADER;
				push.cmd.count = run_left_q;
				push.push      = accept && (run_left_q != '0);
			end
			default: begin
				phase_d        = rbd_pkg::PH_HEADER;
				push.cmd.count = hdr_count;
				unique case (hdr_code)
					rbd_pkg::CODE_LITERAL: begin
						run_left_d = hdr_count;
						if (hdr_count != '0) begin
							phase_d = rbd_pkg::PH_LITERAL;
						end
					end
					rbd_pkg::CODE_REPEAT: begin
						run_left_d = hdr_count;
						phase_d    = rbd_pkg::PH_VALUE;
					end
					rbd_pkg::CODE_ZEROS: begin
						run_left_d     = '0;
						push.cmd.value = rbd_pkg::FILL_ZERO;
						push.push      = accept && (hdr_count != '0);
					end
					default: begin
						run_left_d     = '0;
						push.cmd.value = rbd_pkg::FILL_ONE;
						push.push      = accept && (hdr_count != '0);
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= rbd_pkg::PH_HEADER;
			run_left_q <= '0;
		end else if (cfg_we) begin
			phase_q    <= rbd_pkg::PH_HEADER;
			run_left_q <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			run_left_q <= run_left_d;
		end
	end

`ifndef SYNTH
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push.push)
		else $error("command pushed into a full queue");
	a_literal_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == rbd_pkg::PH_LITERAL) |-> (run_left_q != '0))
		else $error("literal phase with no literals left");
	a_push_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> (push.cmd.count != '0))
		else $error("empty command pushed");
`endif

endmodule

// ===== hw/rtl/rbd_cmd_queue.sv =====
// Two-entry command queue between the front end and the emitter.
module rbd_cmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  rbd_pkg::push_t    push,
	input  logic              pop,
	output logic              full,
	output rbd_pkg::head_t    head
);

	rbd_pkg::cmd_t head_q;
	rbd_pkg::cmd_t tail_q;
	logic [1:0]    count_q;

	assign full       = (count_q == 2'd2);
	assign head.empty = (count_q == 2'd0);
	assign head.head  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			priority if (push.push && pop) begin
				count_q <= count_q;
			end else if (push.push) begin
				count_q <= count_q + 2'd1;
			end else if (pop) begin
				count_q <= count_q - 2'd1;
			end else begin
				count_q <= count_q;
			end
		end
	end

	// The head entry always holds the oldest command; the tail only backs it up.
	always_ff @(posedge clk) begin
		if (push.push && pop) begin
			if (count_q == 2'd2) begin
				head_q <= tail_q;
				tail_q <= push.cmd;
			end else begin
				head_q <= push.cmd;
			end
		end else if (push.push) begin
			if (count_q == 2'd0) begin
				head_q <= push.cmd;
			end else begin
				tail_q <= push.cmd;
			end
		end else if (pop && count_q == 2'd2) begin
			head_q <= tail_q;
		end
	end

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !head.empty)
		else $error("pop from an empty queue");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push.push && !pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("push without pop did not grow the queue");
`endif

endmodule

// ===== hw/rtl/rbd_back.sv =====
// Back end: expands commands into output bytes and keeps the block byte count.
module rbd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rbd_pkg::CFG_BITS-1:0] cfg_wdata,
	input  rbd_pkg::head_t               head,
	output logic                         pop,
	rbd_out_if.source                    data
);

	logic [rbd_pkg::CFG_BITS-1:0]    block_len_q;
	logic [rbd_pkg::LENGTH_BITS-1:0] bytes_left_q;
	logic                            busy_q;
	logic [rbd_pkg::BYTE_BITS-1:0]   cur_value_q;
	logic [rbd_pkg::COUNT_BITS-1:0]  cur_left_q;
	logic                            cur_end_q;
	logic                            out_valid_q;
	logic [rbd_pkg::BYTE_BITS-1:0]   out_data_q;
	logic                            out_last_q;
	logic                            out_done_q;
	logic                            out_over_q;

	logic                            emit;
	logic                            last;
	logic                            over;
	logic                            done;
	logic [rbd_pkg::LENGTH_BITS-1:0] left_dec;

	assign pop      = !busy_q && !head.empty;
	assign emit     = busy_q && (!out_valid_q || data.ready);
	assign last     = (cur_left_q == rbd_pkg::COUNT_BITS'(1));
	assign over     = (bytes_left_q == '0);
	assign left_dec = over ? bytes_left_q : bytes_left_q - rbd_pkg::LENGTH_BITS'(1);
	assign done     = last && cur_end_q && (left_dec == '0);

	assign data.valid      = out_valid_q;
	assign data.data_byte  = out_data_q;
	assign data.run_last   = out_last_q;
	assign data.block_done = out_done_q;
	assign data.overrun    = out_over_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_q  <= '0;
			bytes_left_q <= '0;
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				block_len_q  <= cfg_wdata;
				bytes_left_q <= cfg_wdata[rbd_pkg::LENGTH_BITS-1:0];
			end else if (emit) begin
				bytes_left_q <= done ? block_len_q[rbd_pkg::LENGTH_BITS-1:0] : left_dec;
			end
			if (pop) begin
				busy_q <= 1'b1;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (data.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_value_q <= head.head.value;
			cur_left_q  <= head.head.count;
			cur_end_q   <= head.head.end_run;
		end else if (emit) begin
			cur_left_q <= cur_left_q - rbd_pkg::COUNT_BITS'(1);
		end
		if (emit) begin
			out_data_q <= cur_value_q;
			out_last_q <= last;
			out_done_q <= done;
			out_over_q <= over;
		end
	end

`ifndef SYNTH
	a_busy_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cur_left_q != '0))
		else $error("emitter busy with nothing left to emit");
	a_overrun_matches: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (data.overrun == $past(bytes_left_q == '0)))
		else $error("overrun flag disagrees with the block count");
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		data.valid |-> (!data.block_done || data.run_last))
		else $error("block end flagged on a byte that does not end a run");
	a_done_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && done && !cfg_we) |=> (bytes_left_q == $past(block_len_q[rbd_pkg::LENGTH_BITS-1:0])))
		else $error("block count not reloaded at block end");
`endif

endmodule

// ===== hw/rtl/rle_byte_decoder.sv =====
// Top level of the run-length byte decoder.
//
//   Channel    Direction  Transaction carries
//   code       in         code_byte: one compressed byte
//   data       out        data_byte, run_last, block_done, overrun
//   cfg_we     in         cfg_wdata: block length, written without handshake
//
// A compressed byte is taken whenever the two-entry command queue has room.
// The emitter produces one decoded byte per cycle while the output is taken, and loading
// the next command is a separate step between runs in which no byte is emitted.
// The input stalls once the queue fills behind it.
// The output register lets a new byte be produced in the cycle the previous one is taken.
// Reset (arst_n low) returns the decoder to expect a header with a block length of zero.
// A block length write also restarts the block and the header phase.
module rle_byte_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rbd_pkg::CFG_BITS-1:0] cfg_wdata,
	rbd_in_if.sink                       code,
	rbd_out_if.source                    data
);

	rbd_pkg::push_t push;
	rbd_pkg::head_t head;
	logic           q_full;
	logic           pop;

	rbd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.code   (code),
		.q_full (q_full),
		.push   (push)
	);

	rbd_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	rbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.pop       (pop),
		.data      (data)
	);

endmodule
